@@ rtl/crl_pkg.sv @@
package crl_pkg;

    // Width of the image epoch tag kept in every hash slot
    localparam int EPOCH_W = 4;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Width of the label field on the output port
    localparam int LABEL_OUT_W = 10;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLEAR = 4'b0010,
        S_ISSUE = 4'b0100,
        S_PROBE = 4'b1000
    } t_state;

    typedef struct packed {
        logic is_new;
        logic overflow;
    } t_flags;

endpackage

@@ rtl/crl_table.sv @@
module crl_table #(
    parameter int AW = 11,
    parameter int DW = 38
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    // Write one slot per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register read data; hold it while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/crl_out_reg.sv @@
module crl_out_reg
    import crl_pkg::*;
#(
    parameter int LW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic [LW-1:0] i_label,
    input  t_flags        i_flags,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [LW-1:0] o_label,
    output t_flags        o_flags
);

    logic          r_valid;
    logic [LW-1:0] r_label;
    t_flags        r_flags;

    assign o_free = !r_valid || i_ready;

    // Track whether a result word is waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the payload on load, hold it otherwise
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_label <= i_label;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_label = r_label;
    assign o_flags = r_flags;

endmodule

@@ rtl/color_to_region_label.sv @@
// Dense region labels for a colour-coded segmentation image.
//
// Input channel (i_valid / o_ready): one pixel word per transfer in raster
// order, with a start-of-image flag that empties the colour table first.
// Output channel (o_valid / i_ready): one result word per pixel: label,
// new-region flag and overflow flag, in pixel order.
//
// Colours live in a hash table of 2*2^clog2(LABEL_CAPACITY) slots in one
// single-port-read RAM; each slot holds an image epoch tag, the colour and
// its label. A pixel is accepted with its slot read, then compared and written
// back; linear probing reads one further slot for every occupied slot passed.
// The next pixel is accepted only after the current write-back.
//
// After reset the block sweeps the RAM once, one slot per cycle, with o_ready
// low. The epoch tag wraps every 15th start of image; that start flag triggers
// the same sweep before its pixel. When the receiver stalls, the finished
// result stays in the output register and the lookup holds its last compare
// until the register frees up.
module color_to_region_label
    import crl_pkg::*;
#(
    parameter int LABEL_CAPACITY = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_start_of_image,
    input  logic [7:0]             i_red,
    input  logic [7:0]             i_green,
    input  logic [7:0]             i_blue,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [LABEL_OUT_W-1:0] o_region_label,
    output logic                   o_is_new_region,
    output logic                   o_table_overflow
);

    localparam int LW  = $clog2(LABEL_CAPACITY);
    localparam int CW  = $clog2(LABEL_CAPACITY + 1);
    localparam int IW  = LW + 1;
    localparam int KW  = 24;
    localparam int SW  = EPOCH_W + KW + LW;
    localparam int NCH = (KW + IW - 1) / IW;
    localparam logic [CW-1:0] CAP = CW'(LABEL_CAPACITY);

    // Fold the colour key into a slot index
    function automatic logic [IW-1:0] f_hash(input logic [KW-1:0] key);
        logic [IW-1:0] h;
        h = '0;
        for (int c = 0; c < NCH; c++) begin
            h = h ^ IW'(key >> (c * IW));
        end
        return h;
    endfunction

    t_state        r_state, n_state;
    logic [IW-1:0] r_addr, n_addr;
    logic [KW-1:0] r_key, n_key;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [CW-1:0] r_used, n_used;
    logic          r_pending, n_pending;

    logic [KW-1:0] in_key;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [SW-1:0] wr_data;
    logic [SW-1:0] slot;
    logic [LW-1:0] slot_label;
    logic [KW-1:0] slot_key;
    logic [EPOCH_W-1:0] slot_epoch;
    logic          slot_empty;
    logic          slot_hit;
    logic          table_room;
    logic          out_free;
    logic          out_load;
    logic [LW-1:0] out_label;
    t_flags        out_flags;
    logic [LW-1:0] res_label;
    t_flags        res_flags;

    assign in_key     = {i_red, i_green, i_blue};
    assign slot_label = slot[LW-1:0];
    assign slot_key   = slot[LW+KW-1:LW];
    assign slot_epoch = slot[SW-1:LW+KW];
    assign slot_empty = slot_epoch != r_epoch;
    assign slot_hit   = !slot_empty && (slot_key == r_key);
    assign table_room = r_used < CAP;
    assign o_ready    = r_state == S_IDLE;

    // Sequence accept, clearing sweep and probing
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_key     = r_key;
        n_epoch   = r_epoch;
        n_used    = r_used;
        n_pending = r_pending;
        rd_en     = 1'b0;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_data   = '0;
        out_load  = 1'b0;
        out_label = '0;
        out_flags = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key = in_key;
                    if (i_start_of_image) begin
                        n_used = '0;
                    end
                    if (i_start_of_image && (r_epoch == EPOCH_LAST)) begin
                        n_state   = S_CLEAR;
                        n_addr    = '0;
                        n_pending = 1'b1;
                    end else begin
                        if (i_start_of_image) begin
                            n_epoch = r_epoch + EPOCH_FIRST;
                        end
                        rd_en   = 1'b1;
                        rd_addr = f_hash(in_key);
                        n_addr  = rd_addr;
                        n_state = S_PROBE;
                    end
                end
            end
            S_CLEAR: begin
                wr_en  = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == '1) begin
                    n_epoch = EPOCH_FIRST;
                    n_state = r_pending ? S_ISSUE : S_IDLE;
                end
            end
            S_ISSUE: begin
                rd_en     = 1'b1;
                rd_addr   = f_hash(r_key);
                n_addr    = rd_addr;
                n_pending = 1'b0;
                n_state   = S_PROBE;
            end
            S_PROBE: begin
                if (slot_hit || slot_empty) begin
                    out_label = res_label;
                    out_flags = res_flags;
                    if (out_free) begin
                        out_load = 1'b1;
                        n_state  = S_IDLE;
                        if (res_flags.is_new) begin
                            wr_en   = 1'b1;
                            wr_data = {r_epoch, r_key, res_label};
                            n_used  = CW'(r_used + 1'b1);
                        end
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + 1'b1;
                    n_addr  = rd_addr;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Resolve hit, insert or overflow from the slot just read
    always_comb begin
        res_label = '0;
        res_flags = '0;
        if (slot_hit) begin
            res_label = slot_label;
        end else if (table_room) begin
            res_label        = r_used[LW-1:0];
            res_flags.is_new = 1'b1;
        end else begin
            res_flags.overflow = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_addr    <= '0;
            r_epoch   <= '0;
            r_used    <= '0;
            r_pending <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_epoch   <= n_epoch;
            r_used    <= n_used;
            r_pending <= n_pending;
        end
    end

    // Hold the key of the pixel under lookup
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    crl_table #(
        .AW (IW),
        .DW (SW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (slot)
    );

    logic [LW-1:0] q_label;
    t_flags        q_flags;

    crl_out_reg #(
        .LW (LW)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (out_load),
        .i_label (out_label),
        .i_flags (out_flags),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_label (q_label),
        .o_flags (q_flags)
    );

    assign o_region_label   = LABEL_OUT_W'(q_label);
    assign o_is_new_region  = q_flags.is_new;
    assign o_table_overflow = q_flags.overflow;

    // Label counter never passes the capacity
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CAP)
        else $error("label counter above capacity");

    // A live epoch is never the cleared tag outside the sweep
    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_epoch != '0))
        else $error("epoch equals cleared tag");

    // No table write-back in the cycle a pixel is accepted
    a_no_wr_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !(i_valid && o_ready))
        else $error("write-back overlaps accept");

    // A result is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!o_valid || i_ready))
        else $error("result overwrites waiting word");

    // New region and overflow never flag together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_new_region && o_table_overflow))
        else $error("new region and overflow both set");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import crl_pkg::*;

    localparam int          LABEL_CAPACITY = 1024;
    localparam int unsigned RANDOM_ITEMS   = 1350;
    localparam int unsigned BIG_IMAGE_AT   = 10;
    localparam int unsigned STALL_LIMIT    = 20000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned MAX_PRINTED    = 40;

    typedef struct packed {
        logic       sof;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_word;

    typedef struct packed {
        logic [LABEL_OUT_W-1:0] label;
        logic                   is_new;
        logic                   overflow;
    } t_region_word;

    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_valid          = 1'b0;
    logic                   o_ready;
    logic                   i_start_of_image = 1'b0;
    logic [7:0]             i_red            = '0;
    logic [7:0]             i_green          = '0;
    logic [7:0]             i_blue           = '0;
    logic                   o_valid;
    logic                   i_ready          = 1'b0;
    logic [LABEL_OUT_W-1:0] o_region_label;
    logic                   o_is_new_region;
    logic                   o_table_overflow;

    // Pixels waiting to be driven and label words waiting to come out
    t_pixel_word  pixel_q[$];
    t_region_word expected_labels[$];

    // Shadow of the colour table: colour held by each label handed out
    logic [23:0]  colour_of_label[LABEL_CAPACITY];
    int unsigned  labels_issued   = 0;

    int unsigned  total_items     = 1;
    int unsigned  pixels_sent     = 0;
    int unsigned  results_seen    = 0;
    int unsigned  mismatches      = 0;
    int unsigned  images_started  = 0;
    int unsigned  new_regions     = 0;
    int unsigned  overflow_hits   = 0;
    int unsigned  quiet_cycles    = 0;

    color_to_region_label #(
        .LABEL_CAPACITY(LABEL_CAPACITY)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_start_of_image(i_start_of_image),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_region_label  (o_region_label),
        .o_is_new_region (o_is_new_region),
        .o_table_overflow(o_table_overflow)
    );

    always begin
        #2ns i_clk = 1'b1;
        #2ns i_clk = 1'b0;
    end

    // Look up one pixel colour and update the shadow table
    function automatic t_region_word label_pixel(t_pixel_word px);
        logic [23:0]  colour;
        t_region_word res;
        bit           found;
        colour = {px.red, px.green, px.blue};
        res    = '0;
        found  = 1'b0;
        if (px.sof) begin
            labels_issued = 0;
            images_started++;
        end
        for (int unsigned i = 0; i < labels_issued && !found; i++) begin
            if (colour_of_label[i] == colour) begin
                res.label = LABEL_OUT_W'(i);
                found     = 1'b1;
            end
        end
        if (!found) begin
            if (labels_issued < LABEL_CAPACITY) begin
                colour_of_label[labels_issued] = colour;
                res.label  = LABEL_OUT_W'(labels_issued);
                res.is_new = 1'b1;
                labels_issued++;
                new_regions++;
            end else begin
                // Full table: colour is dropped, label forced to zero
                res.overflow = 1'b1;
                overflow_hits++;
            end
        end
        return res;
    endfunction

    // Idle share per phase: sender light / receiver heavy, then swapped, then none
    function automatic int unsigned idle_percent(int unsigned done, bit is_receiver);
        int unsigned phase;
        phase = (done * 3) / total_items;
        if (phase == 0) return is_receiver ? 54 : 17;
        if (phase == 1) return is_receiver ? 17 : 54;
        return 0;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("ERROR: result %0d: %s got %0d, want %0d", results_seen, what, got, want);
        end
    endtask

    task automatic queue_pixel(bit sof, logic [23:0] colour);
        t_pixel_word px;
        px.sof   = sof;
        px.red   = colour[23:16];
        px.green = colour[15:8];
        px.blue  = colour[7:0];
        pixel_q  = {pixel_q, px};
    endtask

    // Driver: hold the word until accepted, then advance or idle
    always @(posedge i_clk) begin
        t_pixel_word next_px;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_labels = {expected_labels,
                    label_pixel({i_start_of_image, i_red, i_green, i_blue})};
                pixels_sent++;
            end
            if (!i_valid || o_ready) begin
                if (pixel_q.size() != 0 &&
                    $urandom_range(99) >= idle_percent(pixels_sent, 1'b0)) begin
                    next_px           = pixel_q.pop_front();
                    i_valid          <= 1'b1;
                    i_start_of_image <= next_px.sof;
                    i_red            <= next_px.red;
                    i_green          <= next_px.green;
                    i_blue           <= next_px.blue;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_region_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_labels.size() == 0) begin
                    report_mismatch("result with no pixel pending, label",
                                    32'(o_region_label), 0);
                end else begin
                    want = expected_labels.pop_front();
                    if (o_region_label !== want.label)
                        report_mismatch("region_label",
                                        32'(o_region_label), 32'(want.label));
                    if (o_is_new_region !== want.is_new)
                        report_mismatch("is_new_region",
                                        32'(o_is_new_region), 32'(want.is_new));
                    if (o_table_overflow !== want.overflow)
                        report_mismatch("table_overflow",
                                        32'(o_table_overflow), 32'(want.overflow));
                end
            end
            i_ready <= ($urandom_range(99) >= idle_percent(results_seen, 1'b1));
        end
    end

    // Watchdog: drop the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ERROR: no transfer for %0d cycles", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        logic [23:0] big_palette[$];
        logic [23:0] small_pal[6];
        logic [23:0] cand;
        int unsigned directed_items;
        int unsigned img;
        int unsigned npix;
        int unsigned ncol;
        int unsigned sel;
        bit          dup;

        // Directed: extremes, repeats, back-to-back starts, single-bit neighbors
        queue_pixel(1'b0, 24'h000000);
        queue_pixel(1'b0, 24'hFFFFFF);
        queue_pixel(1'b0, 24'h000000);
        queue_pixel(1'b0, 24'hFF0000);
        queue_pixel(1'b0, 24'h00FF00);
        queue_pixel(1'b0, 24'h0000FF);
        queue_pixel(1'b0, 24'hFFFFFF);
        queue_pixel(1'b1, 24'hFFFFFF);
        queue_pixel(1'b1, 24'hFFFFFF);
        queue_pixel(1'b0, 24'h000000);
        queue_pixel(1'b0, 24'h000001);
        queue_pixel(1'b0, 24'h800000);
        queue_pixel(1'b0, 24'h7FFFFF);
        queue_pixel(1'b0, 24'h010000);
        queue_pixel(1'b0, 24'h000001);
        queue_pixel(1'b1, 24'hAA55AA);
        queue_pixel(1'b0, 24'h55AA55);
        queue_pixel(1'b0, 24'hAA55AA);
        directed_items = pixel_q.size();

        // Random: many small images, one image that fills the table and overflows
        for (img = 0; pixel_q.size() < directed_items + RANDOM_ITEMS; img++) begin
            if (img == BIG_IMAGE_AT) begin
                big_palette.delete();
                cand = 24'($urandom);
                big_palette = {big_palette, cand};
                queue_pixel(1'b1, cand);
                while (big_palette.size() < LABEL_CAPACITY + 6) begin
                    if ($urandom_range(99) < 10) begin
                        cand = big_palette[$urandom_range(big_palette.size() - 1)];
                    end else begin
                        do begin
                            cand = 24'($urandom);
                            dup  = 1'b0;
                            foreach (big_palette[k]) if (big_palette[k] == cand) dup = 1'b1;
                        end while (dup);
                        big_palette = {big_palette, cand};
                    end
                    queue_pixel(1'b0, cand);
                end
                // Revisit overflowed and stored colours on the full table
                queue_pixel(1'b0, big_palette[big_palette.size() - 1]);
                queue_pixel(1'b0, big_palette[0]);
                queue_pixel(1'b0, big_palette[LABEL_CAPACITY - 1]);
                queue_pixel(1'b0, big_palette[LABEL_CAPACITY]);
                for (int r = 0; r < 6; r++)
                    queue_pixel(1'b0, big_palette[$urandom_range(big_palette.size() - 1)]);
            end else begin
                npix = $urandom_range(16, 2);
                ncol = $urandom_range(6, 1);
                foreach (small_pal[k]) small_pal[k] = 24'($urandom);
                for (int unsigned p = 0; p < npix; p++) begin
                    sel = $urandom_range(99);
                    if (sel < 70)
                        cand = small_pal[$urandom_range(ncol - 1)];
                    else if (sel < 85)
                        cand = small_pal[$urandom_range(ncol - 1)] ^
                               (24'(1) << $urandom_range(23));
                    else
                        cand = 24'($urandom);
                    // Mostly a start on the first pixel; now and then a missing or stray one
                    if (p == 0)
                        queue_pixel($urandom_range(9) != 0, cand);
                    else
                        queue_pixel($urandom_range(49) == 0, cand);
                end
            end
        end
        total_items = pixel_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixels_sent != total_items || expected_labels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d pixels in %0d image starts, %0d results checked",
                 pixels_sent, images_started, results_seen);
        $display("Summary: %0d new regions, %0d full-table overflows",
                 new_regions, overflow_hits);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
